[rtl/core/qslc_pkg.sv]
package qslc_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 12;
	localparam logic [CNT_W-1:0] CNT_MAX = 12'd4095;

	// sequencer states
	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_POP   = 4'd1;
	localparam logic [3:0] ST_RDPIV = 4'd2;
	localparam logic [3:0] ST_PIVW  = 4'd3;
	localparam logic [3:0] ST_SCANR = 4'd4;
	localparam logic [3:0] ST_SCANC = 4'd5;
	localparam logic [3:0] ST_SWPR  = 4'd6;
	localparam logic [3:0] ST_SWPW  = 4'd7;
	localparam logic [3:0] ST_PUSH  = 4'd8;
	localparam logic [3:0] ST_OUTR  = 4'd9;
	localparam logic [3:0] ST_OUTW  = 4'd10;
	localparam logic [3:0] ST_OUTH  = 4'd11;
	localparam logic [3:0] ST_START = 4'd12;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c == CNT_MAX) ? c : c + 1'b1;
	endfunction

endpackage

[rtl/core/qslc_ram.sv]
// one write port, one registered read port
module qslc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/core/quicksort_lomuto_counting_unit.sv]
// Lomuto quicksort unit. Signed 32-bit values load one beat per cycle into a
// MAX_ELEMENTS-entry store; the beat with tlast closes the array (beats past
// a full store are dropped, tlast still closes). The block then sorts with a
// single comparator and one single-port-read store under a sequencer, pivot =
// last element of each range, pending ranges on an explicit stack. Each
// compare reads the element (SCANR, PIVW); a swap reads the fill slot and
// writes both slots (SCANC, SWPR, SWPW), the pivot swap via SCANR, SWPR,
// SWPW; sorting time is dominated by the store read latency. Sorted values
// then stream out, each read from the store before it is offered, tlast on
// the final one, each carrying this array's compare and swap counts.
// s_tready is low from the closing beat until the last result is taken.
module quicksort_lomuto_counting_unit #(
	parameter int MAX_ELEMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // element_value[31:0]
	input  logic        s_tlast,   // is_final
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // sorted_value[31:0], compare_total[43:32], exchange_total[55:44]
	output logic        m_tlast    // end_of_array
);
	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int NW = $clog2(MAX_ELEMENTS + 1);
	localparam int SW = 2 * AW;
	// pending ranges are disjoint and at least two long, so half the store depth suffices
	localparam int SD  = (MAX_ELEMENTS < 4) ? 2 : MAX_ELEMENTS / 2;
	localparam int SDW = $clog2(SD);

	logic [3:0] state_q;
	logic [NW-1:0] count_q;
	logic [AW-1:0] lo_q, hi_q, k_q, fill_q, out_q;
	logic [SDW:0] sp_q;
	logic [31:0] pivot_q, tmp_q, outv_q;
	logic [qslc_pkg::CNT_W-1:0] cmp_q, xch_q;
	logic swap_hi_q, outlast_q;

	// stack
	logic [SW-1:0] stk_q [SD];

	// element store
	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0] wdata, rdata;

	qslc_ram #(.DEPTH(MAX_ELEMENTS), .WIDTH(32)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic lt;
	assign lt = $signed(rdata) < $signed(pivot_q);

	assign s_tready = (state_q == qslc_pkg::ST_LOAD);

	// combinational store control
	always_comb begin
		we    = 1'b0;
		waddr = k_q;
		wdata = tmp_q;
		raddr = k_q;
		case (state_q)
			qslc_pkg::ST_LOAD: begin
				we    = s_tvalid && (count_q < NW'(MAX_ELEMENTS));
				waddr = count_q[AW-1:0];
				wdata = s_tdata;
			end
			qslc_pkg::ST_POP: raddr = hi_q;
			qslc_pkg::ST_SCANR: begin
				// end of range: fetch store[fill] for the pivot swap
				if (k_q == hi_q) begin
					raddr = fill_q;
				end
			end
			qslc_pkg::ST_SCANC: raddr = fill_q;
			qslc_pkg::ST_SWPR: begin
				// rdata = store[fill]; write store[fill] <= store[k], or the pivot for the pivot swap
				we    = 1'b1;
				waddr = fill_q;
				wdata = swap_hi_q ? pivot_q : tmp_q;
			end
			qslc_pkg::ST_SWPW: begin
				we    = 1'b1;
				waddr = swap_hi_q ? hi_q : k_q;
				wdata = tmp_q;
			end
			qslc_pkg::ST_OUTR: raddr = out_q;
			default: ;
		endcase
	end

	logic [AW-1:0] top_lo, top_hi;
	assign top_lo = stk_q[sp_q[SDW-1:0] - 1'b1][SW-1:AW];
	assign top_hi = stk_q[sp_q[SDW-1:0] - 1'b1][AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= qslc_pkg::ST_LOAD;
			count_q   <= '0;
			sp_q      <= '0;
			cmp_q     <= '0;
			xch_q     <= '0;
			m_tvalid  <= 1'b0;
			swap_hi_q <= 1'b0;
		end else begin
			case (state_q)
				qslc_pkg::ST_LOAD: begin
					if (s_tvalid) begin
						if (count_q < NW'(MAX_ELEMENTS)) count_q <= count_q + 1'b1;
						if (s_tlast) state_q <= qslc_pkg::ST_START;
					end
				end
				qslc_pkg::ST_START: begin
					cmp_q <= '0;
					xch_q <= '0;
					out_q <= '0;
					if (count_q >= NW'(2)) begin
						stk_q[0] <= {AW'(0), AW'(count_q - 1'b1)};
						sp_q     <= (SDW+1)'(1);
						state_q  <= qslc_pkg::ST_PUSH;
					end else begin
						sp_q    <= '0;
						state_q <= qslc_pkg::ST_PUSH;
					end
				end
				qslc_pkg::ST_PUSH: begin
					// dispatch: pop next range or go emit
					if (sp_q == '0) begin
						state_q <= qslc_pkg::ST_OUTR;
					end else begin
						lo_q    <= top_lo;
						hi_q    <= top_hi;
						k_q     <= top_lo;
						fill_q  <= top_lo;
						sp_q    <= sp_q - 1'b1;
						state_q <= (top_lo < top_hi) ? qslc_pkg::ST_POP : qslc_pkg::ST_PUSH;
					end
				end
				qslc_pkg::ST_POP: state_q <= qslc_pkg::ST_RDPIV;
				qslc_pkg::ST_RDPIV: begin
					pivot_q <= rdata;
					state_q <= qslc_pkg::ST_SCANR;
				end
				qslc_pkg::ST_SCANR: begin
					// address k presented; check end of range
					if (k_q == hi_q) begin
						swap_hi_q <= 1'b1;
						xch_q     <= qslc_pkg::sat_inc(xch_q);
						state_q   <= qslc_pkg::ST_SWPR;
					end else begin
						state_q <= qslc_pkg::ST_PIVW;
					end
				end
				qslc_pkg::ST_PIVW: begin
					cmp_q <= qslc_pkg::sat_inc(cmp_q);
					if (lt) begin
						tmp_q   <= rdata;
						xch_q   <= qslc_pkg::sat_inc(xch_q);
						state_q <= qslc_pkg::ST_SCANC;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= qslc_pkg::ST_SCANR;
					end
				end
				qslc_pkg::ST_SCANC: state_q <= qslc_pkg::ST_SWPR;
				qslc_pkg::ST_SWPR: begin
					// rdata holds store[fill]; it goes to k (or hi)
					tmp_q   <= rdata;
					state_q <= qslc_pkg::ST_SWPW;
				end
				qslc_pkg::ST_SWPW: begin
					if (swap_hi_q) begin
						swap_hi_q <= 1'b0;
						if (fill_q + 1'b1 < hi_q && fill_q != hi_q) begin
							stk_q[sp_q[SDW-1:0]] <= {fill_q + 1'b1, hi_q};
							if (fill_q > lo_q + 1'b1) begin
								stk_q[sp_q[SDW-1:0] + 1'b1] <= {lo_q, fill_q - 1'b1};
								sp_q <= sp_q + 2'd2;
							end else begin
								sp_q <= sp_q + 1'b1;
							end
						end else if (fill_q > lo_q + 1'b1) begin
							stk_q[sp_q[SDW-1:0]] <= {lo_q, fill_q - 1'b1};
							sp_q <= sp_q + 1'b1;
						end
						state_q <= qslc_pkg::ST_PUSH;
					end else begin
						fill_q  <= fill_q + 1'b1;
						k_q     <= k_q + 1'b1;
						state_q <= qslc_pkg::ST_SCANR;
					end
				end
				qslc_pkg::ST_OUTR: state_q <= qslc_pkg::ST_OUTW;
				qslc_pkg::ST_OUTW: begin
					outv_q    <= rdata;
					outlast_q <= (NW'(out_q) + 1'b1 == count_q) || (count_q <= NW'(1));
					m_tvalid  <= 1'b1;
					state_q   <= qslc_pkg::ST_OUTH;
				end
				qslc_pkg::ST_OUTH: begin
					if (m_tready) begin
						m_tvalid <= 1'b0;
						out_q    <= out_q + 1'b1;
						if (outlast_q) begin
							count_q <= '0;
							state_q <= qslc_pkg::ST_LOAD;
						end else begin
							state_q <= qslc_pkg::ST_OUTR;
						end
					end
				end
				default: state_q <= qslc_pkg::ST_LOAD;
			endcase
		end
	end

	assign m_tdata = {xch_q, cmp_q, outv_q};
	assign m_tlast = outlast_q;

	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> state_q == qslc_pkg::ST_OUTH) else $error("valid outside output");
	a_no_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("load during output");
	a_stack: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= (SDW+1)'(SD)) else $error("stack overflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NW'(MAX_ELEMENTS)) else $error("count overflow");
endmodule

[bench/quicksort_lomuto_counting_checker.sv]
module quicksort_lomuto_counting_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY = 64;

	typedef struct packed {
		logic [11:0] exchanges;
		logic [11:0] compares;
		logic [31:0] value;
		logic        last;
	} sorted_beat_t;

	logic signed [31:0] held_values [CAPACITY];
	int                 held_count;
	sorted_beat_t       sorted_queue [$];

	function automatic logic [11:0] bump_sat(input logic [11:0] c);
		return (c == 12'hFFF) ? c : c + 12'd1;
	endfunction

	// lomuto sort of the held array, queueing one beat per element
	task automatic sort_and_queue();
		logic signed [31:0] a [CAPACITY];
		int          lo_stack [$];
		int          hi_stack [$];
		logic [11:0] cmp;
		logic [11:0] swp;
		logic signed [31:0] pivot;
		logic signed [31:0] t;
		int lo, hi, fill;
		sorted_beat_t b;
		a = held_values;
		cmp = '0;
		swp = '0;
		if (held_count >= 2) begin
			lo_stack.push_back(0);
			hi_stack.push_back(held_count - 1);
		end
		while (lo_stack.size() > 0) begin
			lo = lo_stack.pop_back();
			hi = hi_stack.pop_back();
			if (lo >= hi) continue;
			pivot = a[hi];
			fill = lo;
			for (int k = lo; k < hi; k++) begin
				cmp = bump_sat(cmp);
				if (a[k] < pivot) begin
					swp = bump_sat(swp);
					t = a[fill]; a[fill] = a[k]; a[k] = t;
					fill++;
				end
			end
			swp = bump_sat(swp);
			t = a[fill]; a[fill] = a[hi]; a[hi] = t;
			if (fill + 1 < hi) begin
				lo_stack.push_back(fill + 1);
				hi_stack.push_back(hi);
			end
			if (fill > lo + 1) begin
				lo_stack.push_back(lo);
				hi_stack.push_back(fill - 1);
			end
		end
		for (int k = 0; k < held_count; k++) begin
			b.value = a[k];
			b.last = (k == held_count - 1);
			b.compares = cmp;
			b.exchanges = swp;
			sorted_queue.push_back(b);
		end
		held_count = 0;
	endtask

	initial begin
		fail_count = 0;
		held_count = 0;
		pending_count = 0;
	end

	always @(posedge clk) begin
		sorted_beat_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_queue.size() == 0) begin
				$display("%0t: unexpected beat tdata=%h tlast=%b", $time, m_tdata, m_tlast);
				fail_count++;
			end else begin
				e = sorted_queue.pop_front();
				if (m_tdata[31:0] !== e.value) begin
					$display("%0t: value expected %h actual %h", $time, e.value, m_tdata[31:0]);
					fail_count++;
				end
				if (m_tlast !== e.last) begin
					$display("%0t: tlast expected %b actual %b", $time, e.last, m_tlast);
					fail_count++;
				end
				if (m_tdata[43:32] !== e.compares) begin
					$display("%0t: compares expected %0d actual %0d", $time, e.compares,
						m_tdata[43:32]);
					fail_count++;
				end
				if (m_tdata[55:44] !== e.exchanges) begin
					$display("%0t: swaps expected %0d actual %0d", $time, e.exchanges,
						m_tdata[55:44]);
					fail_count++;
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			// beats past a full store are dropped, tlast still closes
			if (held_count < CAPACITY) begin
				held_values[held_count] = s_tdata;
				held_count++;
			end
			if (s_tlast) sort_and_queue();
		end
		pending_count = sorted_queue.size();
	end
endmodule

[bench/quicksort_lomuto_counting_unit_tb.sv]
module quicksort_lomuto_counting_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // element_value[31:0]
	logic        s_tlast;   // is_final
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // sorted_value[31:0], compare_total[43:32], exchange_total[55:44]
	logic        m_tlast;   // end_of_array
	int          fail_count;
	int          pending_count;
	int          cycle_count;
	bit          calm_phase;  // no idling on either side while set

	quicksort_lomuto_counting_unit dut (.*);

	quicksort_lomuto_counting_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// receiver: random stalls, none during the calm phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm_phase || ($urandom_range(99) >= 35);
		end
	end

	// watchdog, well above the slowest sort of 64 elements per array
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 2000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// one beat, holding through backpressure; random idle before it
	// tvalid stays high after the beat until the next beat or a drain
	task automatic send_beat(input logic [31:0] value, input logic last);
		while (!calm_phase && $urandom_range(99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	// random content, occasionally the extremes or a narrow range for duplicates
	function automatic logic [31:0] pick_value();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2, 3: return $urandom_range(7) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_array(input int len);
		for (int k = 0; k < len; k++) send_beat(pick_value(), k == len - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	initial begin
		int sent;
		int len;
		cycle_count = 0;
		calm_phase = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single element, extremes, sorted and reversed, duplicates
		send_beat(32'h8000_0000, 1'b1);
		send_beat(32'h7FFF_FFFF, 1'b1);
		send_beat(32'h7FFF_FFFF, 1'b0);
		send_beat(32'h8000_0000, 1'b0);
		send_beat(32'hFFFF_FFFF, 1'b0);
		send_beat(32'h0000_0000, 1'b1);
		for (int k = 0; k < 5; k++) send_beat(k, k == 4);
		for (int k = 5; k > 0; k--) send_beat(k - 3, k == 1);
		for (int k = 0; k < 4; k++) send_beat(32'h5A5A_A5A5, k == 3);
		// sender holds off until everything has drained
		wait_drained();

		// full store, then overflow beats that are dropped, the last closing
		calm_phase = 1'b1;
		for (int k = 0; k < 64; k++) send_beat($urandom, 1'b0);
		for (int k = 0; k < 3; k++) send_beat($urandom, k == 2);
		calm_phase = 1'b0;

		// random arrays, mostly short
		sent = 0;
		while (sent < 43) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(64, 30) : $urandom_range(12, 1);
			if (len > 43 - sent) len = 43 - sent;
			send_array(len);
			sent += len;
		end

		wait_drained();
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
